// ----- sv/bli_pkg.sv -----
// Shared types and constants for the battery LED indicator policy.
// Used by bli_core and battery_led_indicator_policy; no dependencies.
package bli_pkg;

  // Blink timing for the forced idle pattern.
  localparam int BLINK_PERIOD_TICKS = 4;
  localparam int BLINK_ON_TICKS     = 2;

  // The status tick counter wraps at twice the blink period, so that both
  // the parity and the phase within one period stay exact.
  localparam int TICK_WRAP = 2 * BLINK_PERIOD_TICKS;
  localparam int TICK_W    = $clog2(TICK_WRAP);

  localparam logic [TICK_W-1:0] TICK_LAST   = TICK_W'(TICK_WRAP - 1);
  localparam logic [TICK_W-1:0] TICK_PERIOD = TICK_W'(BLINK_PERIOD_TICKS);
  localparam logic [TICK_W-1:0] TICK_ON     = TICK_W'(BLINK_ON_TICKS);

  localparam logic [6:0] FULL_DUTY = 7'd100;

  // Item kinds.
  localparam logic OP_STATUS = 1'b0;
  localparam logic OP_TIME   = 1'b1;

  // Power states.
  localparam logic [2:0] PS_CHARGE      = 3'd0;
  localparam logic [2:0] PS_DISCHARGE   = 3'd1;
  localparam logic [2:0] PS_ERROR       = 3'd2;
  localparam logic [2:0] PS_NEAR_FULL   = 3'd3;
  localparam logic [2:0] PS_IDLE        = 3'd4;
  localparam logic [2:0] PS_FORCED_IDLE = 3'd5;

  // Register map of the configuration port.
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_LOW_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_CRIT_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_LOW_STEP       = 3'd2;
  localparam logic [2:0] REG_CRIT_STEP      = 3'd3;
  localparam logic [2:0] REG_HOLD_UNITS     = 3'd4;

  typedef struct packed {
    logic [6:0] low_threshold;
    logic [6:0] critical_threshold;
    logic [6:0] low_decay_step;
    logic [6:0] critical_decay_step;
    logic [3:0] hold_units;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic              low_latched;
    logic              critical_latched;
    logic              pulse_running;
    logic [6:0]        pulse_duty;
    logic [6:0]        pulse_step;
    logic [3:0]        pulse_wait;
    logic [6:0]        white_level;
    logic [6:0]        amber_level;
  } state_t;

endpackage

// ----- sv/battery_led_indicator_policy.sv -----
// Top level of the battery LED indicator policy: handshakes, configuration
// registers and the policy state. Depends on bli_pkg and bli_core.
//
// Input channel (in_valid/in_ready) carries one item per beat: a status tick
// (opcode 0) with power state, charge percent and auto flag, or a pulse time
// tick (opcode 1). Output channel (out_valid/out_ready) returns one beat per
// item with the white and amber duties being driven after that item.
// An item goes into an input register, then through one stage of policy
// logic into the result register, which raises out_valid; one item is
// accepted every cycle while out_ready is high.
// The policy state updates when the item moves into the result register.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more item; in_ready drops only when both are full.
// Reset (rst, synchronous) clears the state and both handshakes and loads
// the configuration defaults: low threshold 8, critical threshold 5, decay
// steps 3 and 7, hold 5 units. The APB port is always ready; registers lie
// at byte offsets 0x0 to 0x10. They are to be written by the user only while
// the block is idle; the block itself does not enforce this.
module battery_led_indicator_policy (
  input  logic                        clk,
  input  logic                        rst,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bli_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [2:0]                  power_state,
  input  logic [6:0]                  charge_percent,
  input  logic                        auto_enabled,
  // output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [6:0]                  white_duty,
  output logic [6:0]                  amber_duty
);
  import bli_pkg::*;

  cfg_t       cfg;
  state_t     st;
  state_t     st_next;
  logic [2:0] reg_idx;
  logic       cfg_write;

  logic       s1_valid;
  logic       s1_opcode;
  logic [2:0] s1_power_state;
  logic [6:0] s1_charge_percent;
  logic       s1_auto_enabled;
  logic       s1_advance;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold       <= 7'd8;
      cfg.critical_threshold  <= 7'd5;
      cfg.low_decay_step      <= 7'd3;
      cfg.critical_decay_step <= 7'd7;
      cfg.hold_units          <= 4'd5;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_LOW_THRESHOLD:  cfg.low_threshold       <= pwdata[6:0];
        REG_CRIT_THRESHOLD: cfg.critical_threshold  <= pwdata[6:0];
        REG_LOW_STEP:       cfg.low_decay_step      <= pwdata[6:0];
        REG_CRIT_STEP:      cfg.critical_decay_step <= pwdata[6:0];
        REG_HOLD_UNITS:     cfg.hold_units          <= pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_LOW_THRESHOLD:  prdata = 32'(cfg.low_threshold);
      REG_CRIT_THRESHOLD: prdata = 32'(cfg.critical_threshold);
      REG_LOW_STEP:       prdata = 32'(cfg.low_decay_step);
      REG_CRIT_STEP:      prdata = 32'(cfg.critical_decay_step);
      REG_HOLD_UNITS:     prdata = 32'(cfg.hold_units);
      default:            prdata = 32'd0;
    endcase
  end

  // Handshake flow: the input register moves on whenever the result
  // register is empty or its beat is being taken.
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode         <= opcode;
      s1_power_state    <= power_state;
      s1_charge_percent <= charge_percent;
      s1_auto_enabled   <= auto_enabled;
    end
  end

  // Policy logic for the item in the input register.
  bli_core u_core (
    .opcode         (s1_opcode),
    .power_state    (s1_power_state),
    .charge_percent (s1_charge_percent),
    .auto_enabled   (s1_auto_enabled),
    .cfg            (cfg),
    .st             (st),
    .st_next        (st_next)
  );

  // Policy state commits as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      white_duty <= st_next.white_level;
      amber_duty <= st_next.amber_level;
    end
  end

  // The two colors are never lit together.
  a_one_color: assert property (@(posedge clk) disable iff (rst)
    out_valid && (white_duty != 7'd0) |-> (amber_duty == 7'd0))
    else $error("white and amber both lit");

  // Only one alarm latch at a time.
  a_one_alarm: assert property (@(posedge clk) disable iff (rst)
    !(st.low_latched && st.critical_latched))
    else $error("low and critical alarms latched together");

  // A latched alarm always has its pulse running.
  a_alarm_pulse: assert property (@(posedge clk) disable iff (rst)
    (st.low_latched || st.critical_latched) |-> st.pulse_running)
    else $error("alarm latched without a running pulse");

  // Pulse duty stays within percent range.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    st.pulse_duty <= FULL_DUTY)
    else $error("pulse duty above full");

  // An item leaving the input register always shows up as a result beat.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> out_valid)
    else $error("result beat lost");

endmodule

// ----- sv/bli_core.sv -----
// Next-state logic of the LED policy: one item against the current state.
// Purely combinational; depends on bli_pkg.
module bli_core (
  input  logic            opcode,
  input  logic [2:0]      power_state,
  input  logic [6:0]      charge_percent,
  input  logic            auto_enabled,
  input  bli_pkg::cfg_t   cfg,
  input  bli_pkg::state_t st,
  output bli_pkg::state_t st_next
);
  import bli_pkg::*;

  logic [TICK_W-1:0] tick_inc;
  logic [TICK_W-1:0] tick_phase;
  logic              blink_on;
  logic [6:0]        decayed;
  logic              crit_hit;
  logic              low_hit;
  logic              clear_hit;

  // Status tick counter and the forced idle phase within one period.
  assign tick_inc   = (st.tick_count == TICK_LAST) ? '0 : st.tick_count + 1'b1;
  assign tick_phase = (tick_inc >= TICK_PERIOD) ? tick_inc - TICK_PERIOD : tick_inc;
  assign blink_on   = (tick_phase < TICK_ON);

  // Pulse decay with a floor at zero.
  assign decayed = (st.pulse_step >= st.pulse_duty) ? 7'd0 : st.pulse_duty - st.pulse_step;

  // Alarm decisions while discharging; critical is tested first.
  assign crit_hit  = (charge_percent <= cfg.critical_threshold) && !st.critical_latched;
  assign low_hit   = (charge_percent <= cfg.low_threshold) &&
                     (charge_percent > cfg.critical_threshold) && !st.low_latched;
  assign clear_hit = (charge_percent > cfg.low_threshold) &&
                     !st.critical_latched && !st.low_latched;

  always_comb begin
    st_next = st;
    if (opcode == OP_STATUS) begin
      st_next.tick_count = tick_inc;
      if (auto_enabled) begin
        case (power_state)
          PS_CHARGE: begin
            st_next.white_level = 7'd0;
            st_next.amber_level = FULL_DUTY;
          end
          PS_DISCHARGE: begin
            if (crit_hit || low_hit) begin
              // Starting a pulse takes its first step at once: jump to full.
              st_next.low_latched      = low_hit && !crit_hit;
              st_next.critical_latched = crit_hit;
              st_next.pulse_step       = crit_hit ? cfg.critical_decay_step
                                                  : cfg.low_decay_step;
              st_next.pulse_running    = 1'b1;
              st_next.pulse_duty       = FULL_DUTY;
              st_next.pulse_wait       = cfg.hold_units;
              st_next.white_level      = 7'd0;
              st_next.amber_level      = FULL_DUTY;
            end else if (clear_hit) begin
              st_next.white_level = 7'd0;
              st_next.amber_level = 7'd0;
            end
          end
          PS_ERROR: begin
            st_next.white_level = 7'd0;
            st_next.amber_level = tick_inc[0] ? FULL_DUTY : 7'd0;
          end
          PS_NEAR_FULL, PS_IDLE: begin
            st_next.white_level = FULL_DUTY;
            st_next.amber_level = 7'd0;
          end
          PS_FORCED_IDLE: begin
            st_next.white_level = 7'd0;
            st_next.amber_level = blink_on ? FULL_DUTY : 7'd0;
          end
          default: begin
          end
        endcase
      end
      // Leaving discharge cancels the pulse and both alarms.
      if (power_state != PS_DISCHARGE) begin
        st_next.low_latched      = 1'b0;
        st_next.critical_latched = 1'b0;
        st_next.pulse_running    = 1'b0;
      end
    end else if (st.pulse_running) begin
      if (st.pulse_wait > 4'd1) begin
        st_next.pulse_wait = st.pulse_wait - 4'd1;
      end else begin
        // Pulse step: restart from zero, otherwise decay.
        if (st.pulse_duty == 7'd0) begin
          st_next.pulse_duty = FULL_DUTY;
          st_next.pulse_wait = cfg.hold_units;
        end else begin
          st_next.pulse_duty = decayed;
          st_next.pulse_wait = 4'd1;
        end
        st_next.white_level = 7'd0;
        st_next.amber_level = st_next.pulse_duty;
      end
    end
  end

endmodule

// ----- verif/tb_battery_led_indicator_policy.sv -----
// Testbench for battery_led_indicator_policy: directed and random status and
// time ticks, each result beat checked against a behavioral policy model.
// Depends on bli_pkg and the RTL of battery_led_indicator_policy.
module tb_battery_led_indicator_policy;
  import bli_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int MAX_REPORTS     = 10;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 4;

  // One input beat and one result beat.
  typedef struct packed {
    logic       op;
    logic [2:0] pstate;
    logic [6:0] pct;
    logic       auto_en;
  } tick_t;

  typedef struct packed {
    logic [6:0] white;
    logic [6:0] amber;
  } duties_t;

  // Clock, reset and every block input start at known values.
  logic                clk            = 1'b0;
  logic                rst            = 1'b1;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic                opcode         = 1'b0;
  logic [2:0]          power_state    = 3'd0;
  logic [6:0]          charge_percent = 7'd0;
  logic                auto_enabled   = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [6:0]          white_duty;
  logic [6:0]          amber_duty;

  // Stimulus and checking bookkeeping.
  tick_t   pending_ticks[$];
  duties_t expected_duties[$];
  tick_t   next_tick;
  duties_t want;
  int      send_idle_pct     = 0;
  int      recv_stall_pct    = 0;
  int      hold_off_requests = 0;
  int      hold_off_served   = 0;
  int      hold_left         = 0;
  int      error_count       = 0;
  int      result_count      = 0;
  int      idle_cycles       = 0;

  // Model copy of the configuration and the policy state.
  cfg_t        cfg;
  int          tick_count   = 0;
  bit          low_latched  = 1'b0;
  bit          crit_latched = 1'b0;
  bit          pulse_on     = 1'b0;
  logic [6:0]  pulse_duty   = 7'd0;
  logic [6:0]  pulse_step   = 7'd0;
  logic [3:0]  pulse_wait   = 4'd0;
  duties_t     led          = '0;

  battery_led_indicator_policy u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .power_state    (power_state),
    .charge_percent (charge_percent),
    .auto_enabled   (auto_enabled),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .white_duty     (white_duty),
    .amber_duty     (amber_duty)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // One pulse action: jump to full duty and hold, or decay by the step.
  function automatic void fire_pulse();
    if (pulse_duty == 7'd0) begin
      pulse_duty = FULL_DUTY;
      pulse_wait = cfg.hold_units;
    end else begin
      pulse_duty = (pulse_step >= pulse_duty) ? 7'd0 : pulse_duty - pulse_step;
      pulse_wait = 4'd1;
    end
    led = '{white: 7'd0, amber: pulse_duty};
  endfunction

  function automatic void start_pulse(input logic [6:0] step);
    pulse_step = step;
    pulse_duty = 7'd0;
    pulse_on   = 1'b1;
    fire_pulse();
  endfunction

  // Alarm latching while discharging; critical is tested first.
  function automatic void apply_discharge(input logic [6:0] pct);
    if (pct <= cfg.critical_threshold && !crit_latched) begin
      low_latched  = 1'b0;
      crit_latched = 1'b1;
      start_pulse(cfg.critical_decay_step);
    end else if (pct <= cfg.low_threshold && pct > cfg.critical_threshold &&
                 !low_latched) begin
      crit_latched = 1'b0;
      low_latched  = 1'b1;
      start_pulse(cfg.low_decay_step);
    end else if (pct > cfg.low_threshold && !crit_latched && !low_latched) begin
      led = '0;
    end
  endfunction

  // Advances the model by one accepted beat and returns the driven duties.
  function automatic duties_t predict_duties(input tick_t t);
    if (t.op == OP_STATUS) begin
      tick_count = (tick_count + 1) % TICK_WRAP;
      if (t.auto_en) begin
        case (t.pstate)
          PS_CHARGE: led = '{white: 7'd0, amber: FULL_DUTY};
          PS_DISCHARGE: apply_discharge(t.pct);
          PS_ERROR: led = '{white: 7'd0, amber: tick_count[0] ? FULL_DUTY : 7'd0};
          PS_NEAR_FULL, PS_IDLE: led = '{white: FULL_DUTY, amber: 7'd0};
          PS_FORCED_IDLE: begin
            led = '{white: 7'd0,
                    amber: (tick_count % BLINK_PERIOD_TICKS < BLINK_ON_TICKS) ?
                           FULL_DUTY : 7'd0};
          end
          default: ;
        endcase
      end
      if (t.pstate != PS_DISCHARGE) begin
        low_latched  = 1'b0;
        crit_latched = 1'b0;
        pulse_on     = 1'b0;
      end
    end else if (pulse_on) begin
      if (pulse_wait > 4'd1) pulse_wait = pulse_wait - 4'd1;
      else fire_pulse();
    end
    return led;
  endfunction

  function automatic tick_t status_tick(input logic [2:0] ps, input logic [6:0] pct,
                                       input logic auto_en);
    return '{op: OP_STATUS, pstate: ps, pct: pct, auto_en: auto_en};
  endfunction

  // Time ticks carry random content in the fields the block ignores.
  function automatic tick_t time_tick();
    return '{op: OP_TIME, pstate: 3'($urandom), pct: 7'($urandom), auto_en: 1'($urandom)};
  endfunction

  // Charge levels cluster around the thresholds now in force.
  function automatic logic [6:0] pick_charge();
    case ($urandom_range(0, 3))
      0: return cfg.low_threshold + 7'($urandom_range(0, 2)) - 7'd1;
      1: return cfg.critical_threshold + 7'($urandom_range(0, 2)) - 7'd1;
      2: return 7'($urandom_range(0, 100));
      default: return 7'($urandom);
    endcase
  endfunction

  // Mostly discharge episodes paced by time ticks, sometimes plain noise.
  task automatic add_burst();
    int len;
    int roll;
    if ($urandom_range(0, 99) < 80) begin
      len = $urandom_range(20, 90);
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 20) begin
          pending_ticks.push_back(status_tick(PS_DISCHARGE, pick_charge(),
                                              $urandom_range(0, 9) != 0));
        end else if (roll < 24) begin
          pending_ticks.push_back(status_tick(3'($urandom), pick_charge(),
                                              1'($urandom)));
        end else begin
          pending_ticks.push_back(time_tick());
        end
      end
    end else begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) pending_ticks.push_back(tick_t'(12'($urandom)));
    end
  endtask

  // APB write: setup cycle, then access cycle; the model follows the write.
  task automatic write_reg(input logic [2:0] idx, input logic [6:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LOW_THRESHOLD:  cfg.low_threshold       = value;
      REG_CRIT_THRESHOLD: cfg.critical_threshold  = value;
      REG_LOW_STEP:       cfg.low_decay_step      = value;
      REG_CRIT_STEP:      cfg.critical_decay_step = value;
      REG_HOLD_UNITS:     cfg.hold_units          = value[3:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [6:0] low_thr, input logic [6:0] crit_thr,
                           input logic [6:0] low_step, input logic [6:0] crit_step,
                           input logic [3:0] hold);
    write_reg(REG_LOW_THRESHOLD, low_thr);
    write_reg(REG_CRIT_THRESHOLD, crit_thr);
    write_reg(REG_LOW_STEP, low_step);
    write_reg(REG_CRIT_STEP, crit_step);
    write_reg(REG_HOLD_UNITS, 7'(hold));
  endtask

  // Blocks until every queued beat has been sent and answered. The check
  // runs on the falling edge, once the clocked processes have settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_duties.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_random,
                           input bit with_hold_off);
    int target;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = pending_ticks.size() + n_random;
    while (pending_ticks.size() < target) add_burst();
    if (with_hold_off) hold_off_requests++;
    wait_drained();
  endtask

  // Directed opening: every power state, blink phases, both alarms.
  task automatic add_directed();
    pending_ticks.push_back(status_tick(PS_CHARGE, 7'd0, 1'b1));
    pending_ticks.push_back(status_tick(PS_NEAR_FULL, 7'd127, 1'b1));
    pending_ticks.push_back(status_tick(PS_IDLE, 7'd100, 1'b1));
    repeat (2) pending_ticks.push_back(status_tick(PS_ERROR, 7'd50, 1'b1));
    repeat (4) pending_ticks.push_back(status_tick(PS_FORCED_IDLE, 7'd50, 1'b1));
    pending_ticks.push_back(status_tick(3'd6, 7'd50, 1'b1));
    pending_ticks.push_back(status_tick(3'd7, 7'd50, 1'b1));
    pending_ticks.push_back(status_tick(PS_CHARGE, 7'd50, 1'b0));
    pending_ticks.push_back(status_tick(PS_DISCHARGE, 7'd100, 1'b1));
    pending_ticks.push_back(time_tick());
    pending_ticks.push_back(status_tick(PS_DISCHARGE, 7'd15, 1'b1));
    repeat (4) pending_ticks.push_back(time_tick());
    pending_ticks.push_back(status_tick(PS_DISCHARGE, 7'd5, 1'b1));
    repeat (2) pending_ticks.push_back(time_tick());
    pending_ticks.push_back(status_tick(PS_DISCHARGE, 7'd0, 1'b0));
    pending_ticks.push_back(time_tick());
    pending_ticks.push_back(status_tick(PS_CHARGE, 7'd127, 1'b0));
    pending_ticks.push_back(time_tick());
  endtask

  // Sender: a new beat is chosen only once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_tick = pending_ticks.pop_front();
        in_valid       <= 1'b1;
        opcode         <= next_tick.op;
        power_state    <= next_tick.pstate;
        charge_percent <= next_tick.pct;
        auto_enabled   <= next_tick.auto_en;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_off_served != hold_off_requests) begin
      hold_off_served <= hold_off_served + 1;
      hold_left       <= HOLD_OFF_CYCLES;
      out_ready       <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: check result beats first, then predict for the accepted input.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_duties.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result beat %0d: white %0d amber %0d",
                     result_count, white_duty, amber_duty);
          end
        end else begin
          want = expected_duties.pop_front();
          if (white_duty !== want.white || amber_duty !== want.amber) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("result beat %0d: expected white %0d amber %0d, got white %0d amber %0d",
                       result_count, want.white, want.amber, white_duty, amber_duty);
            end
          end
        end
        result_count++;
      end
      if (in_valid && in_ready) begin
        expected_duties.push_back(predict_duties('{op: opcode, pstate: power_state,
                                                   pct: charge_percent,
                                                   auto_en: auto_enabled}));
      end
    end
  end

  // Watchdog: too long without any beat while work is outstanding.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (pending_ticks.size() == 0 && !in_valid && expected_duties.size() == 0)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg.low_threshold       = 7'd8;
    cfg.critical_threshold  = 7'd5;
    cfg.low_decay_step      = 7'd3;
    cfg.critical_decay_step = 7'd7;
    cfg.hold_units          = 4'd5;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Short hold and big steps so the directed pulses finish quickly.
    configure(7'd20, 7'd10, 7'd40, 7'd60, 4'd2);
    @(negedge clk);
    add_directed();
    run_phase(0, 0, 80, 1'b0);

    // Widest threshold window, slowest and fastest decay, longest hold.
    configure(7'd100, 7'd0, 7'd1, 7'd100, 4'd15);
    run_phase(78, 0, 110, 1'b0);

    // Inverted thresholds, zero step, step above full duty, hold of zero.
    configure(7'd0, 7'd100, 7'd0, 7'd127, 4'd0);
    run_phase(0, 78, 110, 1'b0);

    configure(7'd127, 7'd127, 7'($urandom_range(1, 100)), 7'($urandom_range(1, 100)), 4'd1);
    run_phase(10, 10, 110, 1'b0);

    // Random thresholds; the receiver holds off long enough to fill the block.
    configure(7'($urandom_range(10, 40)), 7'($urandom_range(0, 10)),
              7'($urandom_range(1, 20)), 7'($urandom_range(1, 20)),
              4'($urandom_range(1, 15)));
    run_phase(0, 0, 110, 1'b1);

    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_duties.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bli_pkg.sv
sv/bli_core.sv
sv/battery_led_indicator_policy.sv
verif/tb_battery_led_indicator_policy.sv
